FILE: rtl/idsa_pkg.sv
`default_nettype none
package idsa_pkg;

  // Canonical quiet NaN and infinity exponent field
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [7:0]  ExpMax   = 8'hFF;

  // Operand class after unpacking
  typedef enum logic [1:0] {
    ClsNorm = 2'd0,
    ClsZero = 2'd1,
    ClsInf  = 2'd2,
    ClsNan  = 2'd3
  } fp_cls_e;

  // Multiplier partial result between the product and rounding stages
  typedef struct packed {
    logic               sign;
    fp_cls_e            cls;
    logic signed [12:0] expo;
    logic [47:0]        prod;
  } mul_part_t;

  // Leading zero count of a 64-bit word (64 when zero)
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  // Classify one binary32 operand
  function automatic fp_cls_e classify(input logic [31:0] a);
    fp_cls_e c;
    if (a[30:23] == ExpMax) c = (a[22:0] != 23'd0) ? ClsNan : ClsInf;
    else if (a[30:0] == 31'd0) c = ClsZero;
    else c = ClsNorm;
    return c;
  endfunction

  // Effective exponent (subnormals count as exponent one)
  function automatic logic [7:0] eff_exp(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
  endfunction

  // Significand with hidden bit
  function automatic logic [23:0] signif(input logic [31:0] a);
    return {(a[30:23] != 8'd0), a[22:0]};
  endfunction

  // Round to nearest even and pack; mn has its leading one at bit 47
  function automatic logic [31:0] round_pack(input logic sign, input logic signed [12:0] be,
                                             input logic [47:0] mn, input logic stk);
    logic [5:0]         extra;
    logic signed [12:0] t;
    logic [79:0]        sh;
    logic [23:0]        q;
    logic               up;
    logic [24:0]        qr;
    logic [7:0]         base;
    logic [31:0]        pk;
    extra = 6'd0;
    if (mn == 48'd0) return {sign, 31'd0};
    if (be >= 13'sd255) return {sign, ExpMax, 23'd0};
    if (be < 13'sd1) begin
      t = 13'sd1 - be;
      extra = (t > 13'sd25) ? 6'd25 : t[5:0];
    end
    sh   = {mn, 32'd0} >> extra;
    q    = sh[79:56];
    up   = sh[55] & ((|sh[54:0]) | stk | q[0]);
    qr   = {1'b0, q} + {24'd0, up};
    t    = be - 13'sd1;
    base = (be < 13'sd1) ? 8'd0 : t[7:0];
    pk   = {1'b0, base, 23'd0} + {7'd0, qr};
    return {sign, pk[30:0]};
  endfunction

  // Signed 32-bit integer to binary32
  function automatic logic [31:0] int_to_fp(input logic [31:0] v);
    logic        sign;
    logic [31:0] mag;
    logic [6:0]  lz;
    logic [63:0] nrm;
    sign = v[31];
    mag  = sign ? (32'd0 - v) : v;
    if (mag == 32'd0) return 32'd0;
    lz  = lzc64({mag, 32'd0});
    nrm = {mag, 32'd0} << lz;
    return round_pack(sign, 13'sd158 - 13'(lz), nrm[63:16], 1'b0);
  endfunction

  // Multiply, first half: classes, exponent and exact product
  function automatic mul_part_t mul_a(input logic [31:0] a, input logic [31:0] b);
    mul_part_t r;
    fp_cls_e   ca;
    fp_cls_e   cb;
    ca = classify(a);
    cb = classify(b);
    r.sign = a[31] ^ b[31];
    if (ca == ClsNan || cb == ClsNan) r.cls = ClsNan;
    else if ((ca == ClsInf && cb == ClsZero) || (ca == ClsZero && cb == ClsInf))
      r.cls = ClsNan;
    else if (ca == ClsInf || cb == ClsInf) r.cls = ClsInf;
    else if (ca == ClsZero || cb == ClsZero) r.cls = ClsZero;
    else r.cls = ClsNorm;
    r.expo = 13'(eff_exp(a)) + 13'(eff_exp(b)) - 13'sd126;
    r.prod = 48'(signif(a)) * 48'(signif(b));
    return r;
  endfunction

  // Multiply, second half: special results, or normalize and round
  function automatic logic [31:0] mul_b(input mul_part_t p);
    logic [6:0]  lz;
    logic [63:0] nrm;
    logic [31:0] r;
    lz  = lzc64({p.prod, 16'd0});
    nrm = {p.prod, 16'd0} << lz;
    case (p.cls)
      ClsNan:  r = CanonNan;
      ClsInf:  r = {p.sign, ExpMax, 23'd0};
      ClsZero: r = {p.sign, 31'd0};
      default: r = round_pack(p.sign, p.expo - 13'(lz), nrm[63:16], 1'b0);
    endcase
    return r;
  endfunction

  // Binary32 addition
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    fp_cls_e     ca;
    fp_cls_e     cb;
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  d;
    logic [50:0] fa;
    logic [50:0] fb;
    logic [50:0] bs;
    logic        stk;
    logic [50:0] rs;
    logic [6:0]  lz;
    logic [63:0] nrm;
    ca = classify(a);
    cb = classify(b);
    if (ca == ClsNan || cb == ClsNan) return CanonNan;
    if (ca == ClsInf && cb == ClsInf && a[31] != b[31]) return CanonNan;
    if (ca == ClsInf) return {a[31], ExpMax, 23'd0};
    if (cb == ClsInf) return {b[31], ExpMax, 23'd0};
    if ({eff_exp(a), signif(a)} < {eff_exp(b), signif(b)}) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    d  = eff_exp(x) - eff_exp(y);
    fa = {1'b0, signif(x), 26'd0};
    fb = {1'b0, signif(y), 26'd0};
    if (d > 8'd50) begin
      bs  = 51'd0;
      stk = (signif(y) != 24'd0);
    end else begin
      bs  = fb >> d;
      stk = |(fb & ((51'd1 << d) - 51'd1));
    end
    bs = {bs[50:1], bs[0] | stk};
    rs = (x[31] != y[31]) ? (fa - bs) : (fa + bs);
    if (rs == 51'd0) return {a[31] & b[31], 31'd0};
    lz  = lzc64({rs, 13'd0});
    nrm = {rs, 13'd0} << lz;
    return round_pack(x[31], 13'(eff_exp(x)) + 13'sd1 - 13'(lz), nrm[63:16], |nrm[15:0]);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/int_dequant_scale_accumulate_unit.sv
`default_nettype none
// Dequantize, scale and accumulate, one element per item.
// Slave stream: tdata carries quant_value [31:0], weight_scale [63:32] and
// old_accum [95:64]; tuser carries last_element. Master stream: tdata carries
// new_accum, tuser carries last_out. All arithmetic is binary32 with
// round-to-nearest-even: int to float, times weight scale, times activation
// scale, plus old accumulator, each rounded on its own. A NaN result is
// always the canonical quiet NaN. The activation scale is written over the
// cfg channel (always ready); the user must write it only while the stream
// is idle, as the block does not enforce it. It resets to 1.0.
// One item per cycle is sustained through a six-stage pipeline (convert, two
// stages per multiply, add). The whole pipeline holds while the receiver
// stalls with a result waiting, and no new item is accepted until that
// result leaves.
// Reset clears all valid bits and loads the activation scale with 1.0.
module int_dequant_scale_accumulate_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // quant_value, weight_scale, old_accum from bit 0 up
  input  wire logic [95:0] s_axis_tdata,
  // last_element
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // new_accum
  output logic [31:0]      m_axis_tdata,
  // last_out
  output logic             m_axis_tuser
);

  localparam int Stages = 6;

  logic [31:0]                act_q;
  logic [Stages-1:0]          vld_q;
  logic [Stages-1:0]          vld_d;
  logic                       en;
  logic [31:0]                conv_q;
  logic [31:0]                ws_q;
  idsa_pkg::mul_part_t        m1_q;
  logic [31:0]                p1_q;
  idsa_pkg::mul_part_t        m2_q;
  logic [31:0]                p2_q;
  logic [31:0]                res_q;
  logic [31:0]                acc_q [Stages-1];
  logic [Stages-1:0]          last_q;

  // Advance everything unless a result waits on a stalled receiver
  assign en            = !vld_q[Stages-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;
  assign vld_d         = {vld_q[Stages-2:0], s_axis_tvalid};

  // Hold activation scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 32'h3F80_0000;
    end else if (cfg_valid_i) begin
      act_q <= cfg_data_i;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      conv_q    <= idsa_pkg::int_to_fp(s_axis_tdata[31:0]);
      ws_q      <= s_axis_tdata[63:32];
      acc_q[0]  <= s_axis_tdata[95:64];
      m1_q      <= idsa_pkg::mul_a(conv_q, ws_q);
      p1_q      <= idsa_pkg::mul_b(m1_q);
      m2_q      <= idsa_pkg::mul_a(p1_q, act_q);
      p2_q      <= idsa_pkg::mul_b(m2_q);
      res_q     <= idsa_pkg::fadd(acc_q[Stages-2], p2_q);
      last_q    <= {last_q[Stages-2:0], s_axis_tuser};
      for (int i = 1; i < Stages - 1; i++) begin
        acc_q[i] <= acc_q[i-1];
      end
    end
  end

  assign m_axis_tvalid = vld_q[Stages-1];
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = last_q[Stages-1];

  // An accepted item enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted item lost at pipeline entry");

  // A stalled pipeline keeps its occupancy
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  // Any NaN leaving the block is canonical
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[30:23] == 8'hFF && m_axis_tdata[22:0] != 23'd0
    |-> m_axis_tdata == idsa_pkg::CanonNan)
    else $error("non-canonical NaN on output");

endmodule
`default_nettype wire

FILE: tb/sv/int_dequant_scale_accumulate_unit_tb.sv
module int_dequant_scale_accumulate_unit_tb;

  typedef logic [319:0] wide_t;

  typedef struct {
    logic [31:0] accum;
    logic        last;
  } accum_item_t;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // quant_value, weight_scale, old_accum from bit 0 up
  logic [95:0] s_axis_tdata = '0;
  // last_element
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // new_accum
  logic [31:0] m_axis_tdata;
  // last_out
  logic        m_axis_tuser;

  logic [31:0]  act_scale = 32'h3F80_0000;
  accum_item_t  pending_accum[$];
  int unsigned  error_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  max_gap = 5;
  int unsigned  rx_stall = 0;

  int_dequant_scale_accumulate_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Round an exact value mag * 2^ex to binary32, nearest even
  function automatic logic [31:0] round_single(input logic sgn, input wide_t mag, input int ex);
    int          p;
    int          qe;
    int          s;
    wide_t       q;
    wide_t       rem;
    wide_t       half;
    logic [63:0] word;
    if (mag == '0) return {sgn, 31'd0};
    p = 319;
    while (!mag[p]) p--;
    qe = p + ex - 23;
    if (qe < -149) qe = -149;
    s = qe - ex;
    if (s <= 0) begin
      q = mag << (-s);
    end else if (s > p + 1) begin
      q = '0;
    end else begin
      q    = mag >> s;
      rem  = mag & ((wide_t'(1) << s) - wide_t'(1));
      half = wide_t'(1) << (s - 1);
      if (rem > half || (rem == half && q[0])) q = q + wide_t'(1);
    end
    // carry out of the significand bumps the exponent on its own
    word = (64'(qe + 149) << 23) + q[63:0];
    if (word >= 64'h7F80_0000) return {sgn, idsa_pkg::ExpMax, 23'd0};
    return {sgn, word[30:0]};
  endfunction

  function automatic logic is_nan(input logic [31:0] a);
    return a[30:23] == idsa_pkg::ExpMax && a[22:0] != 23'd0;
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return a[30:23] == idsa_pkg::ExpMax && a[22:0] == 23'd0;
  endfunction

  // Split a finite operand into integer significand and exponent
  function automatic void split_single(input logic [31:0] a, output wide_t m, output int ex);
    if (a[30:23] == 8'd0) begin
      m  = wide_t'(a[22:0]);
      ex = -149;
    end else begin
      m  = wide_t'({1'b1, a[22:0]});
      ex = int'(a[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
    logic  sgn;
    wide_t ma;
    wide_t mb;
    int    ea;
    int    eb;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return idsa_pkg::CanonNan;
    if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
      return idsa_pkg::CanonNan;
    if (is_inf(a) || is_inf(b)) return {sgn, idsa_pkg::ExpMax, 23'd0};
    split_single(a, ma, ea);
    split_single(b, mb, eb);
    return round_single(sgn, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] single_add(input logic [31:0] a, input logic [31:0] b);
    wide_t ma;
    wide_t mb;
    wide_t mr;
    int    ea;
    int    eb;
    int    emin;
    logic  sgn;
    if (is_nan(a) || is_nan(b)) return idsa_pkg::CanonNan;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return idsa_pkg::CanonNan;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    split_single(a, ma, ea);
    split_single(b, mb, eb);
    emin = (ea < eb) ? ea : eb;
    ma = ma << (ea - emin);
    mb = mb << (eb - emin);
    if (a[31] == b[31]) begin
      mr  = ma + mb;
      sgn = a[31];
    end else if (ma >= mb) begin
      mr  = ma - mb;
      sgn = a[31];
    end else begin
      mr  = mb - ma;
      sgn = b[31];
    end
    // exact cancellation gives +0 unless both addends are negative
    if (mr == '0) return {a[31] & b[31], 31'd0};
    return round_single(sgn, mr, emin);
  endfunction

  function automatic accum_item_t accum_result(input logic [31:0] qv, input logic [31:0] ws,
                                               input logic [31:0] acc, input logic last);
    accum_item_t r;
    logic [31:0] conv;
    logic [31:0] mag;
    mag  = qv[31] ? (32'd0 - qv) : qv;
    conv = round_single(qv[31], wide_t'(mag), 0);
    if (mag == 32'd0) conv = 32'd0;
    r.accum = single_add(acc, single_mul(single_mul(conv, ws), act_scale));
    if (is_nan(r.accum)) r.accum = idsa_pkg::CanonNan;
    r.last = last;
    return r;
  endfunction

  // Predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    accum_item_t exp_item;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      pending_accum.push_back(accum_result(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                           s_axis_tdata[95:64], s_axis_tuser));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rx_stall = $urandom_range(0, max_gap);
      if (pending_accum.size() == 0) begin
        $error("unexpected result new_accum=%h last_out=%b", m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        exp_item = pending_accum.pop_front();
        if (m_axis_tdata !== exp_item.accum) begin
          $error("new_accum expected %h actual %h", exp_item.accum, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser !== exp_item.last) begin
          $error("last_out expected %b actual %b", exp_item.last, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  // Stall the result side for the drawn number of cycles
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready = 1'b0;
    end else if (rx_stall > 0) begin
      m_axis_tready = 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Send one item; called and returns at a falling edge
  task automatic send_item(input logic [31:0] qv, input logic [31:0] ws,
                           input logic [31:0] acc, input logic last);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {acc, ws, qv};
    s_axis_tuser  = last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained;
    s_axis_tvalid = 1'b0;
    while (pending_accum.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_act_scale(input logic [31:0] value);
    wait_drained();
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    act_scale = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_single();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
      1:       v = {$urandom_range(0, 1) == 1, idsa_pkg::ExpMax,
                    23'($urandom_range(0, 1) ? $urandom : 0)};
      2:       v = {$urandom_range(0, 1) == 1, 31'd0};
      3, 4:    v = $urandom;
      default: v = {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 150)), 23'($urandom)};
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_quant();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0:       v = 32'($signed($urandom_range(0, 2000)) - 1000);
      1:       v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_item(rand_quant(), rand_single(), rand_single(), $urandom_range(0, 1) == 1);
  endtask

  // Field extremes and special operands at the reset scale of 1.0
  task automatic test_directed;
    send_item(32'h0000_0000, 32'h3F80_0000, 32'h0000_0000, 1'b0);
    send_item(32'h8000_0000, 32'h3F80_0000, 32'h8000_0000, 1'b1);
    send_item(32'h7FFF_FFFF, 32'h3F80_0000, 32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(32'h0100_0001, 32'h3F80_0000, 32'h0000_0000, 1'b0);
    send_item(32'h0100_0003, 32'h3F80_0000, 32'h0000_0000, 1'b0);
    send_item(32'h7FFF_FFC0, 32'h3F80_0000, 32'h0000_0000, 1'b0);
    send_item(32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 1'b0);
    send_item(32'h0000_0003, 32'h0000_0001, 32'h8000_0001, 1'b0);
    send_item(32'h7FFF_FFFF, 32'h7F7F_FFFF, 32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 32'h7F80_0000, 32'h3F80_0000, 1'b0);
    send_item(32'h0000_0005, 32'hFF80_0000, 32'h7F80_0000, 1'b0);
    send_item(32'h0000_0005, 32'h7F80_0000, 32'h7F80_0000, 1'b1);
    send_item(32'h0000_0005, 32'h7FC1_2345, 32'h3F80_0000, 1'b0);
    send_item(32'h0000_0005, 32'h3F80_0000, 32'hFFA0_0001, 1'b0);
    send_item(32'h0000_0001, 32'h3F80_0000, 32'hBF80_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(32'h0000_0002, 32'h0080_0000, 32'h8000_0000, 1'b0);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1);
    send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
  endtask

  // Random items under a range of activation scales
  task automatic test_scales;
    logic [31:0] scales[8];
    scales = '{32'h0000_0001, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
               32'h7F80_0000, 32'h0000_0000, 32'hC0A0_0000, 32'h3E00_0001};
    foreach (scales[i]) begin
      write_act_scale(scales[i]);
      send_random(60);
    end
  endtask

  task automatic test_random;
    for (int unsigned k = 0; k < 8; k++) begin
      write_act_scale({$urandom_range(0, 1) == 1, 8'($urandom_range(110, 140)), 23'($urandom)});
      // every third stretch runs without any idling
      max_gap = (k % 3 == 0) ? 0 : 5;
      send_random(90);
    end
    max_gap = 5;
  endtask

  // Let the pipeline empty in the middle of a stream
  task automatic test_drain_pause;
    write_act_scale($urandom);
    for (int unsigned k = 0; k < 4; k++) begin
      send_random(25);
      s_axis_tvalid = 1'b0;
      while (pending_accum.size() != 0) @(negedge clk_i);
    end
    write_act_scale(32'h3F80_0000);
    send_random(20);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_scales();
    test_random();
    test_drain_pause();
    wait_drained();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
